// ===== rtl/multi_slot_expiry_timer_top_defines.svh =====
// Assertion macros used by the timer controller RTL.
`ifndef MULTI_SLOT_EXPIRY_TIMER_TOP_DEFINES_SVH
`define MULTI_SLOT_EXPIRY_TIMER_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSET_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MSET_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mset_pkg.sv =====
// Package: sizes, codes, state types and time helpers of the expiry timer.
`default_nettype none

package mset_pkg;

  localparam int SLOTS    = 16;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SLOT_FW  = 4;
  localparam int SEL_W    = (IDX_W > SLOT_FW) ? IDX_W : SLOT_FW;
  localparam int SEC_W    = 32;
  localparam int USEC_W   = 20;
  localparam int FIRE_MAX = 16;
  localparam int FCNT_W   = 5;

  localparam logic [SEC_W-1:0]  SEC_MAX      = '1;
  localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;
  localparam logic [USEC_W:0]   USEC_PER_SEC = 21'd1000000;
  localparam logic [USEC_W:0]   USEC_TWO_SEC = 21'd2000000;
  localparam logic [IDX_W-1:0]  IDX_LAST     = IDX_W'(SLOTS - 1);
  localparam logic [FCNT_W-1:0] FCNT_MAX     = FCNT_W'(FIRE_MAX);

  typedef enum logic [1:0] {
    FUNC_REG    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_CHECK  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic {
    KIND_FIRE  = 1'b0,
    KIND_SCHED = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_EXP,
    ST_APPLY,
    ST_SCAN,
    ST_SCHED
  } state_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              apply;
    func_t             func;
    logic [SEL_W-1:0]  slot;
    logic              went_back;
    logic [SEC_W-1:0]  now_sec;
    logic [USEC_W-1:0] now_usec;
    logic [SEC_W-1:0]  exp_sec;
    logic [USEC_W-1:0] exp_usec;
  } op_t;

  // running minimum handed down the chain
  typedef struct packed {
    logic              have;
    logic [SEC_W-1:0]  sec;
    logic [USEC_W-1:0] usec;
  } min_t;

  // a <= b on normalized (sec, usec) pairs
  function automatic logic time_le(input logic [SEC_W-1:0]  a_sec,
                                   input logic [USEC_W-1:0] a_usec,
                                   input logic [SEC_W-1:0]  b_sec,
                                   input logic [USEC_W-1:0] b_usec);
    return (a_sec < b_sec) || ((a_sec == b_sec) && (a_usec <= b_usec));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mset_ifs.sv =====
// Channel interfaces: request input and result output of the expiry timer.
`default_nettype none

interface mset_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  slot;
  logic [31:0] delay_sec;
  logic [19:0] delay_usec;
  logic [31:0] now_sec;
  logic [19:0] now_usec;

  modport source (output valid, func, slot, delay_sec, delay_usec, now_sec, now_usec,
                  input ready);
  modport sink (input valid, func, slot, delay_sec, delay_usec, now_sec, now_usec,
                output ready);
endinterface

interface mset_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  fired_slot;
  logic [31:0] next_sec;
  logic [19:0] next_usec;
  logic        pending;
  logic        last;

  modport source (output valid, kind, fired_slot, next_sec, next_usec, pending, last,
                  input ready);
  modport sink (input valid, kind, fired_slot, next_sec, next_usec, pending, last,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/mset_cell.sv =====
// One timer slot: armed flag, expiry time, fired flag and a stage of the scan chain.
`default_nettype none

module mset_cell import mset_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  op_t  op,
  input  logic sel,
  input  logic step,
  input  logic tok_in,
  input  min_t min_in,
  output logic tok_out,
  output min_t min_out,
  output logic armed,
  output logic hit
);

  logic              armed_r, armed_nxt;
  logic              fired_r, fired_nxt;
  logic              tok_r;
  logic [SEC_W-1:0]  exp_sec_r;
  logic [USEC_W-1:0] exp_usec_r;
  min_t              min_r, min_nxt;
  logic              live;
  logic              wb_fire;
  logic              due;

  always_comb begin
    live      = armed_r;
    wb_fire   = 1'b0;
    due       = 1'b0;
    armed_nxt = armed_r;
    fired_nxt = fired_r;
    if (op.apply) begin
      if (op.func == FUNC_CLEAR) begin
        armed_nxt = 1'b0;
        fired_nxt = 1'b0;
      end else begin
        if (op.func == FUNC_CANCEL && sel) begin
          live = 1'b0;
        end
        wb_fire = op.went_back & live;
        if (op.went_back) begin
          live = 1'b0;
        end
        due = (op.func == FUNC_CHECK) && live &&
              time_le(exp_sec_r, exp_usec_r, op.now_sec, op.now_usec);
        if (op.func == FUNC_REG && sel) begin
          live = 1'b1;
        end
        armed_nxt = live & ~due;
        fired_nxt = wb_fire | due;
      end
    end
  end

  always_comb begin
    min_nxt = min_in;
    if (armed_r &&
        (!min_in.have || !time_le(min_in.sec, min_in.usec, exp_sec_r, exp_usec_r))) begin
      min_nxt.have = 1'b1;
      min_nxt.sec  = exp_sec_r;
      min_nxt.usec = exp_usec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
      fired_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
      fired_r <= fired_nxt;
      if (op.apply) begin
        tok_r <= 1'b0;
      end else if (step) begin
        tok_r <= tok_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.apply && op.func == FUNC_REG && sel) begin
      exp_sec_r  <= op.exp_sec;
      exp_usec_r <= op.exp_usec;
    end
    if (step && tok_in) begin
      min_r <= min_nxt;
    end
  end

  assign tok_out = tok_r;
  assign min_out = min_r;
  assign armed   = armed_r;
  assign hit     = tok_in & fired_r;

endmodule

`default_nettype wire

// ===== rtl/mset_ctrl.sv =====
// Controller: request intake, time arithmetic, scan sequencing and result register.
`default_nettype none

`include "multi_slot_expiry_timer_top_defines.svh"

module mset_ctrl import mset_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  mset_in_if.sink          in_ch,
  mset_out_if.source       out_ch,
  input  logic [SLOTS-1:0] hits,
  input  logic             pend,
  input  logic             tok_last,
  input  min_t             min_last,
  output op_t              op,
  output logic             tok0,
  output logic             step
);

  state_t            state_r, state_nxt;
  func_t             func_r;
  logic [SEL_W-1:0]  slot_r;
  logic [SEC_W-1:0]  dsec_r;
  logic [USEC_W-1:0] dusec_r;
  logic [SEC_W-1:0]  nsec_r;
  logic [USEC_W-1:0] nusec_r;
  logic [SEC_W-1:0]  now_sec_r;
  logic [USEC_W-1:0] now_usec_r;
  logic              wb_r;
  logic [SEC_W-1:0]  exp_sec_r;
  logic [USEC_W-1:0] exp_usec_r;
  logic [SEC_W-1:0]  last_seen_r;
  logic [IDX_W-1:0]  k_r;
  logic [FCNT_W-1:0] nfire_r;

  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [3:0]        out_slot_r;
  logic [SEC_W-1:0]  out_sec_r;
  logic [USEC_W-1:0] out_usec_r;
  logic              out_pend_r;
  logic              out_last_r;

  logic              accept;
  logic              hit_any;
  logic              emit;
  logic              out_free;
  logic              load_fire;
  logic              load_sched;

  logic [USEC_W:0]   usum;
  logic [USEC_W:0]   unorm;
  logic [1:0]        carry;
  logic [SEC_W+1:0]  ssum;

  logic              later;
  logic              bor;
  logic [USEC_W:0]   du;
  logic [SEC_W-1:0]  ds;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_ch.valid) state_nxt = ST_NORM;
      ST_NORM:  state_nxt = ST_EXP;
      ST_EXP:   state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_SCAN;
      ST_SCAN:  if (step && k_r == IDX_LAST) state_nxt = ST_SCHED;
      ST_SCHED: if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == ST_IDLE);
    hit_any     = |hits;
    out_free    = !out_valid_r || out_ch.ready;
    emit        = (state_r == ST_SCAN) && hit_any && (nfire_r < FCNT_MAX);
    step        = (state_r == ST_SCAN) && (!emit || out_free);
    tok0        = (state_r == ST_SCAN) && (k_r == '0);
    load_fire   = emit && out_free;
    load_sched  = (state_r == ST_SCHED) && out_free;
  end

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    op.apply     = (state_r == ST_APPLY);
    op.func      = func_r;
    op.slot      = slot_r;
    op.went_back = wb_r;
    op.now_sec   = now_sec_r;
    op.now_usec  = now_usec_r;
    op.exp_sec   = exp_sec_r;
    op.exp_usec  = exp_usec_r;
  end

  // expiry = now + delay, microseconds carried into seconds, saturating
  always_comb begin
    usum = {1'b0, now_usec_r} + {1'b0, dusec_r};
    if (usum >= USEC_TWO_SEC) begin
      carry = 2'd2;
      unorm = usum - USEC_TWO_SEC;
    end else if (usum >= USEC_PER_SEC) begin
      carry = 2'd1;
      unorm = usum - USEC_PER_SEC;
    end else begin
      carry = 2'd0;
      unorm = usum;
    end
    ssum = {2'b00, now_sec_r} + {2'b00, dsec_r} + {{SEC_W{1'b0}}, carry};
  end

  // delay from now to the earliest expiry, zero when already due
  always_comb begin
    later = min_last.have &&
            !time_le(min_last.sec, min_last.usec, now_sec_r, now_usec_r);
    bor   = min_last.usec < now_usec_r;
    du    = {1'b0, min_last.usec} + (bor ? USEC_PER_SEC : '0) - {1'b0, now_usec_r};
    ds    = min_last.sec - now_sec_r - {{(SEC_W-1){1'b0}}, bor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      last_seen_r <= '0;
      k_r         <= '0;
      nfire_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_fire || load_sched) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_APPLY) begin
        last_seen_r <= (func_r == FUNC_CLEAR) ? '0 : nsec_r;
        k_r         <= '0;
        nfire_r     <= '0;
      end else begin
        if (step) begin
          k_r <= k_r + 1'b1;
        end
        if (load_fire) begin
          nfire_r <= nfire_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func_t'(in_ch.func);
      slot_r  <= SEL_W'(in_ch.slot);
      dsec_r  <= in_ch.delay_sec;
      dusec_r <= in_ch.delay_usec;
      nsec_r  <= in_ch.now_sec;
      nusec_r <= in_ch.now_usec;
    end
    if (state_r == ST_NORM) begin
      wb_r <= nsec_r < last_seen_r;
      if ({1'b0, nusec_r} >= USEC_PER_SEC) begin
        if (nsec_r == SEC_MAX) begin
          now_sec_r  <= SEC_MAX;
          now_usec_r <= USEC_MAX;
        end else begin
          now_sec_r  <= nsec_r + 1'b1;
          now_usec_r <= USEC_W'({1'b0, nusec_r} - USEC_PER_SEC);
        end
      end else begin
        now_sec_r  <= nsec_r;
        now_usec_r <= nusec_r;
      end
    end
    if (state_r == ST_EXP) begin
      if (ssum[SEC_W+1:SEC_W] != 2'b00) begin
        exp_sec_r  <= SEC_MAX;
        exp_usec_r <= USEC_MAX;
      end else begin
        exp_sec_r  <= ssum[SEC_W-1:0];
        exp_usec_r <= unorm[USEC_W-1:0];
      end
    end
    if (load_fire) begin
      out_kind_r <= KIND_FIRE;
      out_slot_r <= 4'(k_r);
      out_sec_r  <= '0;
      out_usec_r <= '0;
      out_pend_r <= pend;
      out_last_r <= 1'b0;
    end else if (load_sched) begin
      out_kind_r <= KIND_SCHED;
      out_slot_r <= '0;
      out_sec_r  <= later ? ds : '0;
      out_usec_r <= later ? du[USEC_W-1:0] : '0;
      out_pend_r <= pend;
      out_last_r <= 1'b1;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.fired_slot = out_slot_r;
  assign out_ch.next_sec   = out_sec_r;
  assign out_ch.next_usec  = out_usec_r;
  assign out_ch.pending    = out_pend_r;
  assign out_ch.last       = out_last_r;

  `MSET_CHK_NOW(a_hit_scan, hit_any, state_r == ST_SCAN, "fired hit outside the scan")
  `MSET_CHK_NOW(a_hit_one, 1'b1, $onehot0(hits), "several cells hold the scan token")
  `MSET_CHK_NOW(a_hit_pos, hit_any, hits[k_r], "scan token and scan counter disagree")
  `MSET_CHK_NOW(a_pend_min, state_r == ST_SCHED, min_last.have == pend, "pending and minimum disagree")
  `MSET_CHK_NOW(a_done_tok, state_r == ST_SCHED, tok_last, "schedule before the token left the chain")
  `MSET_CHK_NEXT(a_pend_stable, state_r == ST_SCAN, pend == $past(pend), "armed set moved during scan")

endmodule

`default_nettype wire

// ===== rtl/multi_slot_expiry_timer_top.sv =====
// Top level: controller plus a chain of SLOTS timer cells.
//
//   channel  | dir | handshake         | payload
//   in_ch    | in  | valid/ready       | func slot delay_sec delay_usec now_sec now_usec
//   out_ch   | out | valid/ready       | kind fired_slot next_sec next_usec pending last
//
// A request passes through accept, time normalize, expiry add, table update, a scan in which
// the scan token walks the chain cell by cell, then the schedule.
// The scan stops on a fired cell while the result register is still full.
// rst_n is synchronous: it disarms all slots and zeroes the last-seen second; stored
// expiry times are not reset. A new request is taken while the last result still waits.
`default_nettype none

module multi_slot_expiry_timer_top import mset_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mset_in_if.sink    in_ch,
  mset_out_if.source out_ch
);

  op_t              op;
  logic             tok0;
  logic             step;
  logic [SLOTS:0]   tok_chain;
  min_t             min_chain [SLOTS+1];
  logic [SLOTS-1:0] armed_v;
  logic [SLOTS-1:0] hits;
  logic             pend;

  assign tok_chain[0] = tok0;
  assign min_chain[0] = '0;
  assign pend         = |armed_v;

  mset_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .hits     (hits),
    .pend     (pend),
    .tok_last (tok_chain[SLOTS]),
    .min_last (min_chain[SLOTS]),
    .op       (op),
    .tok0     (tok0),
    .step     (step)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mset_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .op      (op),
      .sel     (op.slot == SEL_W'(i)),
      .step    (step),
      .tok_in  (tok_chain[i]),
      .min_in  (min_chain[i]),
      .tok_out (tok_chain[i+1]),
      .min_out (min_chain[i+1]),
      .armed   (armed_v[i]),
      .hit     (hits[i])
    );
  end

endmodule

`default_nettype wire

// ===== test/multi_slot_expiry_timer_top_tb.sv =====
// Self-checking testbench for the multi-slot expiry timer: directed table, then random traffic.
module multi_slot_expiry_timer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mset_pkg::*;

  localparam logic [63:0] USEC_1M        = 64'd1000000;
  localparam logic [63:0] TOTAL_MAX      = 64'd4294967295 * 64'd1000000 + 64'd999999;
  localparam int          RANDOM_ITEMS   = 200;
  localparam int          CALM_ITEMS     = 40;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    func_t       func;
    logic [3:0]  slot;
    logic [31:0] delay_sec;
    logic [19:0] delay_usec;
    logic [31:0] now_sec;
    logic [19:0] now_usec;
  } timer_request_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  fired_slot;
    logic [31:0] next_sec;
    logic [19:0] next_usec;
    logic        pending;
    logic        last;
  } timer_result_t;

  // typed: sched holds the hand-written schedule result for this request
  typedef struct packed {
    timer_request_t rq;
    logic           typed;
    timer_result_t  sched;
  } plan_row_t;

  logic clk;
  logic rst_n;

  mset_in_if  in_ch ();
  mset_out_if out_ch ();

  multi_slot_expiry_timer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // timer table as the block should hold it; expiry kept as total microseconds
  logic [SLOTS-1:0] armed_q;
  logic [63:0]      due_at [SLOTS];
  logic [31:0]      seen_sec;

  timer_result_t due_results [$];
  timer_result_t step_results [$];
  plan_row_t     plan [$];

  int errors      = 0;
  int quiet_cycles = 0;
  int stall_left  = 0;
  bit idle_on     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic plan_row_t row(input func_t f, input logic [3:0] s,
                                    input logic [31:0] dsec, input logic [19:0] dusec,
                                    input logic [31:0] nsec, input logic [19:0] nusec,
                                    input logic typed = 1'b0,
                                    input logic [31:0] esec = 32'd0,
                                    input logic [19:0] eusec = 20'd0,
                                    input logic epend = 1'b0);
    plan_row_t r;
    r = '0;
    r.rq.func            = f;
    r.rq.slot            = s;
    r.rq.delay_sec       = dsec;
    r.rq.delay_usec      = dusec;
    r.rq.now_sec         = nsec;
    r.rq.now_usec        = nusec;
    r.typed              = typed;
    r.sched.kind         = KIND_SCHED;
    r.sched.next_sec     = esec;
    r.sched.next_usec    = eusec;
    r.sched.pending      = epend;
    r.sched.last         = 1'b1;
    return r;
  endfunction

  // applies one request to the table and leaves its results in step_results
  function automatic void predict_timer(input timer_request_t rq);
    logic [63:0]      now_t;
    logic [63:0]      e;
    logic [63:0]      best;
    logic [63:0]      diff;
    logic             have;
    logic [SLOTS-1:0] fired;
    timer_result_t    r;
    int               i;
    now_t = 64'(rq.now_sec) * USEC_1M + 64'(rq.now_usec);
    if (now_t > TOTAL_MAX) now_t = TOTAL_MAX;
    fired = '0;
    have  = 1'b0;
    best  = '0;
    step_results.delete();
    if (rq.func == FUNC_CLEAR) begin
      armed_q  = '0;
      seen_sec = '0;
    end else begin
      if (rq.func == FUNC_CANCEL && int'(rq.slot) < SLOTS) armed_q[rq.slot] = 1'b0;
      if (rq.now_sec < seen_sec) begin
        fired   = armed_q;
        armed_q = '0;
      end
      seen_sec = rq.now_sec;
      if (rq.func == FUNC_REG && int'(rq.slot) < SLOTS) begin
        e = now_t + 64'(rq.delay_sec) * USEC_1M + 64'(rq.delay_usec);
        if (e > TOTAL_MAX) e = TOTAL_MAX;
        due_at[rq.slot]  = e;
        armed_q[rq.slot] = 1'b1;
      end else if (rq.func == FUNC_CHECK) begin
        for (i = 0; i < SLOTS; i++) begin
          if (armed_q[i] && due_at[i] <= now_t) begin
            armed_q[i] = 1'b0;
            fired[i]   = 1'b1;
          end
        end
      end
    end
    for (i = 0; i < SLOTS; i++) begin
      if (armed_q[i] && (!have || due_at[i] < best)) begin
        best = due_at[i];
        have = 1'b1;
      end
    end
    for (i = 0; i < SLOTS; i++) begin
      if (fired[i]) begin
        r            = '0;
        r.kind       = KIND_FIRE;
        r.fired_slot = 4'(i);
        r.pending    = have;
        step_results.push_back(r);
      end
    end
    diff        = (have && best > now_t) ? best - now_t : 64'd0;
    r           = '0;
    r.kind      = KIND_SCHED;
    r.next_sec  = 32'(diff / USEC_1M);
    r.next_usec = 20'(diff % USEC_1M);
    r.pending   = have;
    r.last      = 1'b1;
    step_results.push_back(r);
  endfunction

  task automatic send_request(input plan_row_t pr);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= pr.rq.func;
    in_ch.slot       <= pr.rq.slot;
    in_ch.delay_sec  <= pr.rq.delay_sec;
    in_ch.delay_usec <= pr.rq.delay_usec;
    in_ch.now_sec    <= pr.rq.now_sec;
    in_ch.now_usec   <= pr.rq.now_usec;
    do @(posedge clk); while (!in_ch.ready);
    predict_timer(pr.rq);
    if (pr.typed) due_results.push_back(pr.sched);
    else foreach (step_results[k]) due_results.push_back(step_results[k]);
  endtask

  always @(posedge clk) begin : result_check
    timer_result_t got;
    timer_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind       = kind_t'(out_ch.kind);
      got.fired_slot = out_ch.fired_slot;
      got.next_sec   = out_ch.next_sec;
      got.next_usec  = out_ch.next_usec;
      got.pending    = out_ch.pending;
      got.last       = out_ch.last;
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: kind=%0d slot=%0d next=%0d.%06d pending=%0d last=%0d",
                 $time, got.kind, got.fired_slot, got.next_sec, got.next_usec, got.pending,
                 got.last);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (got !== want) begin
          $display("%0t mismatch expected kind=%0d slot=%0d next=%0d.%06d pending=%0d last=%0d",
                   $time, want.kind, want.fired_slot, want.next_sec, want.next_usec,
                   want.pending, want.last);
          $display("%0t mismatch actual   kind=%0d slot=%0d next=%0d.%06d pending=%0d last=%0d",
                   $time, got.kind, got.fired_slot, got.next_sec, got.next_usec, got.pending,
                   got.last);
          errors++;
        end
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t watchdog: no request or result moved for %0d cycles", $time,
                 quiet_cycles);
        $display("FAIL multi_slot_expiry_timer_top");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t   pr;
    logic [31:0] clock_sec;
    int          sel;
    int          n;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_REG;
    in_ch.slot       = '0;
    in_ch.delay_sec  = '0;
    in_ch.delay_usec = '0;
    in_ch.now_sec    = '0;
    in_ch.now_usec   = '0;
    out_ch.ready     = 1'b0;
    armed_q          = '0;
    seen_sec         = '0;
    clock_sec        = 32'd300;

    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      32'd0,   20'd0,
                       1'b1, 32'd0, 20'd0, 1'b0));
    plan.push_back(row(FUNC_REG,    4'd0,  32'd5,  20'd0,      32'd100, 20'd0,
                       1'b1, 32'd5, 20'd0, 1'b1));
    plan.push_back(row(FUNC_REG,    4'd15, 32'd0,  USEC_MAX,   32'd100, 20'd500000,
                       1'b1, 32'd0, USEC_MAX, 1'b1));
    // expiry saturates
    plan.push_back(row(FUNC_REG,    4'd3,  SEC_MAX, USEC_MAX,  32'd100, 20'd0));
    // re-register overwrites
    plan.push_back(row(FUNC_REG,    4'd15, 32'd10, 20'd0,      32'd100, 20'd0));
    plan.push_back(row(FUNC_CANCEL, 4'd7,  32'd0,  20'd0,      32'd100, 20'd0));
    plan.push_back(row(FUNC_CANCEL, 4'd15, 32'd0,  20'd0,      32'd101, 20'd0));
    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      32'd104, USEC_MAX));
    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      32'd105, 20'd0));
    plan.push_back(row(FUNC_REG,    4'd1,  32'd0,  20'd0,      32'd105, 20'd0));
    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      32'd105, 20'd0));
    // now_usec past one second carries
    plan.push_back(row(FUNC_REG,    4'd2,  32'd1,  20'd0,      32'd105, 20'hFFFFF));
    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      32'd106, 20'hFFFFF));
    plan.push_back(row(FUNC_REG,    4'd5,  32'd50, 20'd0,      32'd200, 20'd0));
    plan.push_back(row(FUNC_REG,    4'd6,  32'd60, USEC_MAX,   32'd200, USEC_MAX));
    // time goes back on a cancel
    plan.push_back(row(FUNC_CANCEL, 4'd6,  32'd0,  20'd0,      32'd150, 20'd0));
    plan.push_back(row(FUNC_REG,    4'd8,  32'd3,  20'd0,      32'd50,  20'd0));
    plan.push_back(row(FUNC_REG,    4'd9,  32'd0,  20'hFFFFF,  SEC_MAX, USEC_MAX));
    plan.push_back(row(FUNC_REG,    4'd10, 32'd1,  20'd0,      SEC_MAX, 20'hFFFFF));
    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      SEC_MAX, USEC_MAX));
    plan.push_back(row(FUNC_REG,    4'd4,  32'd2,  20'd500000, 32'd10,  20'd0));
    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      32'd0,   20'd0));
    plan.push_back(row(FUNC_REG,    4'd12, 32'd1,  20'd0,      32'd0,   20'd0));
    plan.push_back(row(FUNC_CLEAR,  4'd0,  32'd0,  20'd0,      32'd0,   20'd0,
                       1'b1, 32'd0, 20'd0, 1'b0));
    plan.push_back(row(FUNC_CHECK,  4'd0,  32'd0,  20'd0,      32'd0,   20'd0,
                       1'b1, 32'd0, 20'd0, 1'b0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) send_request(plan[k]);

    // mostly a forward-moving clock with short delays, so slots fire on later checks
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = (n < RANDOM_ITEMS - CALM_ITEMS);
      sel     = $urandom_range(0, 99);
      if (sel < 4) clock_sec = $urandom;
      else if (sel < 9) clock_sec = clock_sec - 32'($urandom_range(1, 5));
      else clock_sec = clock_sec + 32'($urandom_range(0, 2));
      pr = '0;
      pr.rq.now_sec  = clock_sec;
      pr.rq.now_usec = ($urandom_range(0, 19) == 0) ? 20'($urandom)
                                                     : 20'($urandom_range(0, 999999));
      sel = $urandom_range(0, 99);
      pr.rq.func = (sel < 45) ? FUNC_REG : (sel < 80) ? FUNC_CHECK :
                   (sel < 96) ? FUNC_CANCEL : FUNC_CLEAR;
      pr.rq.slot       = 4'($urandom_range(0, 15));
      pr.rq.delay_sec  = ($urandom_range(0, 19) == 0) ? 32'($urandom)
                                                       : 32'($urandom_range(0, 4));
      pr.rq.delay_usec = ($urandom_range(0, 19) == 0) ? 20'($urandom)
                                                       : 20'($urandom_range(0, 999999));
      send_request(pr);
    end
    in_ch.valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS multi_slot_expiry_timer_top");
    end else begin
      $display("FAIL multi_slot_expiry_timer_top");
    end
    $finish;
  end

endmodule
